// ===== hdl/cpam_pkg.sv =====
// Shared types and constants for the cascaded PI attitude mixer.
`timescale 1ns / 1ps

package cpam_pkg;

  localparam int ANGLE_W = 16;
  localparam int GAIN_W  = 20;
  localparam int CORR_W  = 11;
  localparam int MOTOR_W = 12;
  localparam int BASE_W  = 11;

  typedef enum logic [3:0] {
    LS_IDLE,
    LS_AERR_DT,
    LS_AERR_KP,
    LS_AI_KI,
    LS_RDES,
    LS_RERR,
    LS_RERR_DT,
    LS_RERR_KP,
    LS_RI_KI,
    LS_CORR
  } lane_state_t;

  typedef enum logic [1:0] {
    T_IDLE,
    T_RUN,
    T_MERGE
  } top_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lane_status_t;

endpackage

// ===== hdl/cpam_lane.sv =====
// One axis lane: outer and inner PI loops sharing a single registered multiplier.
`timescale 1ns / 1ps

module cpam_lane #(
  parameter int MAX_ANGLE_INTEGRAL = 30,
  parameter int MAX_RATE_INTEGRAL  = 20,
  parameter int MAX_DESIRED_RATE   = 20,
  parameter int MAX_CORRECTION     = 200
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [cpam_pkg::ANGLE_W-1:0]  angle,
  input  logic signed [cpam_pkg::ANGLE_W-1:0]  rate,
  input  logic        [15:0]                   dt,
  input  logic signed [cpam_pkg::ANGLE_W-1:0]  target,
  input  logic signed [cpam_pkg::GAIN_W-1:0]   kpo,
  input  logic signed [cpam_pkg::GAIN_W-1:0]   kio,
  input  logic signed [cpam_pkg::GAIN_W-1:0]   kpi,
  input  logic signed [cpam_pkg::GAIN_W-1:0]   kii,
  output logic signed [cpam_pkg::CORR_W-1:0]   corr,
  output cpam_pkg::lane_status_t               status
);

  localparam logic signed [27:0] AI_LIM   = 28'(MAX_ANGLE_INTEGRAL) <<< 16;
  localparam logic signed [28:0] RI_LIM   = 29'(MAX_RATE_INTEGRAL) <<< 16;
  localparam logic signed [47:0] RDES_LIM = 48'(MAX_DESIRED_RATE) <<< 33;
  localparam logic signed [47:0] CORR_LIM = 48'(MAX_CORRECTION) <<< 33;

  cpam_pkg::lane_state_t state, state_next;

  logic signed [16:0] aerr;
  logic signed [15:0] rate_q;
  logic        [15:0] dt_q;
  logic signed [23:0] angle_int;
  logic signed [23:0] rate_int;
  logic signed [25:0] rdes;
  logic signed [26:0] rerr;
  logic signed [47:0] acc;
  logic signed [46:0] prod;

  logic signed [26:0] mul_a;
  logic signed [19:0] mul_b;

  logic signed [27:0] ai_sum, ai_sat;
  logic signed [28:0] ri_sum, ri_sat;
  logic signed [47:0] rsum, rsat;
  logic signed [47:0] csum, csat, cmag;
  logic signed [10:0] corr_pos, corr_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cpam_pkg::LS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    status.busy = (state != cpam_pkg::LS_IDLE);
    status.done = (state == cpam_pkg::LS_CORR);
    case (state)
      cpam_pkg::LS_IDLE:    if (start) state_next = cpam_pkg::LS_AERR_DT;
      cpam_pkg::LS_AERR_DT: state_next = cpam_pkg::LS_AERR_KP;
      cpam_pkg::LS_AERR_KP: state_next = cpam_pkg::LS_AI_KI;
      cpam_pkg::LS_AI_KI:   state_next = cpam_pkg::LS_RDES;
      cpam_pkg::LS_RDES:    state_next = cpam_pkg::LS_RERR;
      cpam_pkg::LS_RERR:    state_next = cpam_pkg::LS_RERR_DT;
      cpam_pkg::LS_RERR_DT: state_next = cpam_pkg::LS_RERR_KP;
      cpam_pkg::LS_RERR_KP: state_next = cpam_pkg::LS_RI_KI;
      cpam_pkg::LS_RI_KI:   state_next = cpam_pkg::LS_CORR;
      cpam_pkg::LS_CORR:    state_next = cpam_pkg::LS_IDLE;
      default:              state_next = cpam_pkg::LS_IDLE;
    endcase
  end

  always_comb begin
    case (state)
      cpam_pkg::LS_AERR_DT: begin
        mul_a = 27'(aerr);
        mul_b = $signed({4'b0000, dt_q});
      end
      cpam_pkg::LS_AERR_KP: begin
        mul_a = 27'(aerr);
        mul_b = kpo;
      end
      cpam_pkg::LS_AI_KI: begin
        mul_a = 27'(angle_int);
        mul_b = kio;
      end
      cpam_pkg::LS_RERR_DT: begin
        mul_a = rerr;
        mul_b = $signed({4'b0000, dt_q});
      end
      cpam_pkg::LS_RERR_KP: begin
        mul_a = rerr;
        mul_b = kpi;
      end
      cpam_pkg::LS_RI_KI: begin
        mul_a = 27'(rate_int);
        mul_b = kii;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    ai_sum = 28'(angle_int) + 28'(prod >>> 6);
    if (ai_sum > AI_LIM) begin
      ai_sat = AI_LIM;
    end else if (ai_sum < -AI_LIM) begin
      ai_sat = -AI_LIM;
    end else begin
      ai_sat = ai_sum;
    end

    ri_sum = 29'(rate_int) + 29'(prod >>> 16);
    if (ri_sum > RI_LIM) begin
      ri_sat = RI_LIM;
    end else if (ri_sum < -RI_LIM) begin
      ri_sat = -RI_LIM;
    end else begin
      ri_sat = ri_sum;
    end

    rsum = acc + 48'(prod);
    if (rsum > RDES_LIM) begin
      rsat = RDES_LIM;
    end else if (rsum < -RDES_LIM) begin
      rsat = -RDES_LIM;
    end else begin
      rsat = rsum;
    end

    csum = acc + 48'(prod);
    if (csum > CORR_LIM) begin
      csat = CORR_LIM;
    end else if (csum < -CORR_LIM) begin
      csat = -CORR_LIM;
    end else begin
      csat = csum;
    end
    cmag     = csat[47] ? -csat : csat;
    corr_pos = $signed(cmag[43:33]);
    corr_val = csat[47] ? -corr_pos : corr_pos;
  end

  always_ff @(posedge clk) begin
    prod <= 47'(mul_a) * 47'(mul_b);
    case (state)
      cpam_pkg::LS_IDLE: begin
        if (start) begin
          aerr   <= 17'(target) - 17'(angle);
          rate_q <= rate;
          dt_q   <= dt;
        end
      end
      cpam_pkg::LS_AI_KI: acc  <= 48'(prod) <<< 10;
      cpam_pkg::LS_RDES:  rdes <= rsat[42:17];
      cpam_pkg::LS_RERR:  rerr <= 27'(rdes) - (27'(rate_q) <<< 10);
      cpam_pkg::LS_RI_KI: acc  <= 48'(prod);
      cpam_pkg::LS_CORR:  corr <= corr_val;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_int <= '0;
      rate_int  <= '0;
    end else begin
      if (state == cpam_pkg::LS_AERR_KP) begin
        angle_int <= ai_sat[23:0];
      end
      if (state == cpam_pkg::LS_RERR_KP) begin
        rate_int <= ri_sat[23:0];
      end
    end
  end

endmodule

// ===== hdl/cpam_mixer.sv =====
// Motor mixer: merges the three axis corrections with base throttle into a result register.
`timescale 1ns / 1ps

module cpam_mixer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                mix_valid,
  output logic                                mix_ready,
  input  logic signed [cpam_pkg::CORR_W-1:0]  corr [3],
  input  logic        [cpam_pkg::BASE_W-1:0]  base,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic        [cpam_pkg::MOTOR_W-1:0] motor_one,
  output logic        [cpam_pkg::MOTOR_W-1:0] motor_two,
  output logic        [cpam_pkg::MOTOR_W-1:0] motor_three,
  output logic        [cpam_pkg::MOTOR_W-1:0] motor_four
);

  logic signed [12:0] base_x;
  logic signed [12:0] sum_one, sum_two, sum_three, sum_four;

  function automatic logic [11:0] motor_clamp(input logic signed [12:0] v);
    logic [11:0] r;
    if (v[12]) begin
      r = '0;
    end else begin
      r = v[11:0];
    end
    return r;
  endfunction

  assign mix_ready = !out_valid || out_ready;

  always_comb begin
    base_x    = $signed({2'b00, base});
    sum_one   = base_x + 13'(corr[1]) + 13'(corr[2]);
    sum_two   = base_x + 13'(corr[0]) - 13'(corr[2]);
    sum_three = base_x - 13'(corr[1]) + 13'(corr[2]);
    sum_four  = base_x - 13'(corr[0]) - 13'(corr[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (mix_valid && mix_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mix_valid && mix_ready) begin
      motor_one   <= motor_clamp(sum_one);
      motor_two   <= motor_clamp(sum_two);
      motor_three <= motor_clamp(sum_three);
      motor_four  <= motor_clamp(sum_four);
    end
  end

endmodule

// ===== hdl/cascaded_pi_attitude_mixer_top.sv =====
// Top level: configuration registers, three axis lanes and the motor mixer.
// A request runs through nine lane steps, then a merge state that loads the mixer output register,
// then returns to idle; a new request is accepted only in idle, once the previous one has merged.
// A new request is taken while the previous result waits; its merge holds until that drains.
// Reset: integrators cleared, registers to defaults, no result pending.
`timescale 1ns / 1ps

module cascaded_pi_attitude_mixer_top #(
  parameter int MAX_ANGLE_INTEGRAL = 30,
  parameter int MAX_RATE_INTEGRAL  = 20,
  parameter int MAX_DESIRED_RATE   = 20,
  parameter int MAX_CORRECTION     = 200
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [cpam_pkg::ANGLE_W-1:0] roll_angle,
  input  logic signed [cpam_pkg::ANGLE_W-1:0] pitch_angle,
  input  logic signed [cpam_pkg::ANGLE_W-1:0] yaw_angle,
  input  logic signed [cpam_pkg::ANGLE_W-1:0] roll_rate,
  input  logic signed [cpam_pkg::ANGLE_W-1:0] pitch_rate,
  input  logic signed [cpam_pkg::ANGLE_W-1:0] yaw_rate,
  input  logic        [15:0]                  sample_interval,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic        [cpam_pkg::MOTOR_W-1:0] motor_one,
  output logic        [cpam_pkg::MOTOR_W-1:0] motor_two,
  output logic        [cpam_pkg::MOTOR_W-1:0] motor_three,
  output logic        [cpam_pkg::MOTOR_W-1:0] motor_four,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic        [2:0]                   cfg_index,
  input  logic        [59:0]                  cfg_data
);

  localparam logic [2:0] CFG_OUTER_PROP  = 3'd0;
  localparam logic [2:0] CFG_OUTER_INTEG = 3'd1;
  localparam logic [2:0] CFG_INNER_PROP  = 3'd2;
  localparam logic [2:0] CFG_INNER_INTEG = 3'd3;
  localparam logic [2:0] CFG_TARGET      = 3'd4;
  localparam logic [2:0] CFG_BASE        = 3'd5;

  logic [59:0] outer_prop_gains;
  logic [59:0] outer_integ_gains;
  logic [59:0] inner_prop_gains;
  logic [59:0] inner_integ_gains;
  logic [47:0] target_attitude;
  logic [cpam_pkg::BASE_W-1:0] base_throttle;

  cpam_pkg::top_state_t state, state_next;
  logic start;
  logic lanes_done;
  logic mix_valid, mix_ready;

  logic signed [cpam_pkg::ANGLE_W-1:0] angle_in [3];
  logic signed [cpam_pkg::ANGLE_W-1:0] rate_in  [3];
  logic signed [cpam_pkg::CORR_W-1:0]  corr     [3];
  cpam_pkg::lane_status_t              lst      [3];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      outer_prop_gains  <= 60'd274878169088;
      outer_integ_gains <= '0;
      inner_prop_gains  <= 60'd504676111876358;
      inner_integ_gains <= '0;
      target_attitude   <= 48'd49478023249920;
      base_throttle     <= 11'd1500;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_OUTER_PROP:  outer_prop_gains  <= cfg_data;
        CFG_OUTER_INTEG: outer_integ_gains <= cfg_data;
        CFG_INNER_PROP:  inner_prop_gains  <= cfg_data;
        CFG_INNER_INTEG: inner_integ_gains <= cfg_data;
        CFG_TARGET:      target_attitude   <= cfg_data[47:0];
        CFG_BASE:        base_throttle     <= cfg_data[cpam_pkg::BASE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cpam_pkg::T_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    mix_valid  = 1'b0;
    case (state)
      cpam_pkg::T_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = cpam_pkg::T_RUN;
      end
      cpam_pkg::T_RUN: begin
        if (lanes_done) state_next = cpam_pkg::T_MERGE;
      end
      cpam_pkg::T_MERGE: begin
        mix_valid = 1'b1;
        if (mix_ready) state_next = cpam_pkg::T_IDLE;
      end
      default: state_next = cpam_pkg::T_IDLE;
    endcase
  end

  assign start      = in_valid && in_ready;
  assign lanes_done = lst[0].done && lst[1].done && lst[2].done;

  assign angle_in[0] = roll_angle;
  assign angle_in[1] = pitch_angle;
  assign angle_in[2] = yaw_angle;
  assign rate_in[0]  = roll_rate;
  assign rate_in[1]  = pitch_rate;
  assign rate_in[2]  = yaw_rate;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    cpam_lane #(
      .MAX_ANGLE_INTEGRAL (MAX_ANGLE_INTEGRAL),
      .MAX_RATE_INTEGRAL  (MAX_RATE_INTEGRAL),
      .MAX_DESIRED_RATE   (MAX_DESIRED_RATE),
      .MAX_CORRECTION     (MAX_CORRECTION)
    ) u_lane (
      .clk    (clk),
      .rst    (rst),
      .start  (start),
      .angle  (angle_in[i]),
      .rate   (rate_in[i]),
      .dt     (sample_interval),
      .target ($signed(target_attitude[i*cpam_pkg::ANGLE_W +: cpam_pkg::ANGLE_W])),
      .kpo    ($signed(outer_prop_gains[i*cpam_pkg::GAIN_W +: cpam_pkg::GAIN_W])),
      .kio    ($signed(outer_integ_gains[i*cpam_pkg::GAIN_W +: cpam_pkg::GAIN_W])),
      .kpi    ($signed(inner_prop_gains[i*cpam_pkg::GAIN_W +: cpam_pkg::GAIN_W])),
      .kii    ($signed(inner_integ_gains[i*cpam_pkg::GAIN_W +: cpam_pkg::GAIN_W])),
      .corr   (corr[i]),
      .status (lst[i])
    );
  end

  cpam_mixer u_mixer (
    .clk         (clk),
    .rst         (rst),
    .mix_valid   (mix_valid),
    .mix_ready   (mix_ready),
    .corr        (corr),
    .base        (base_throttle),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .motor_one   (motor_one),
    .motor_two   (motor_two),
    .motor_three (motor_three),
    .motor_four  (motor_four)
  );

  a_lanes_lockstep: assert property (@(posedge clk) disable iff (rst)
    (lst[0].done == lst[1].done) && (lst[1].done == lst[2].done))
    else $error("axis lanes out of step");

  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |-> !lst[0].busy && !lst[1].busy && !lst[2].busy)
    else $error("request taken while lanes busy");

  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    lst[0].done |-> state == cpam_pkg::T_RUN)
    else $error("lane finished outside run phase");

  a_merge_loads: assert property (@(posedge clk) disable iff (rst)
    (state == cpam_pkg::T_MERGE && mix_ready) |=> out_valid)
    else $error("merged result not loaded");

endmodule
